// ===== rtl/nlc_pkg.sv =====
// newline style converter package: character codes, style and encoding codes,
// register indexes and the job type passed from front to back
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package nlc_pkg;

   // character codes
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // newline styles
   localparam logic [1:0] STYLE_CR   = 2'd0;
   localparam logic [1:0] STYLE_LF   = 2'd1;
   localparam logic [1:0] STYLE_CRLF = 2'd2;

   // character encodings
   localparam logic [1:0] ENC_NONE = 2'd0;
   localparam logic [1:0] ENC_UTF8 = 2'd1;
   localparam logic [1:0] ENC_SJIS = 2'd2;
   localparam logic [1:0] ENC_EUC  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_SOURCE_STYLE  = 2'd0;
   localparam logic [1:0] REG_TARGET_STYLE  = 2'd1;
   localparam logic [1:0] REG_CHAR_ENCODING = 2'd2;

   // reset values of the configuration registers
   localparam logic [1:0] SOURCE_STYLE_RESET  = STYLE_CRLF;
   localparam logic [1:0] TARGET_STYLE_RESET  = STYLE_LF;
   localparam logic [1:0] CHAR_ENCODING_RESET = ENC_NONE;

   // default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // one classified item: one or two output beats
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       two_beats;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/nlc_front.sv =====
// front of the newline style converter: configuration registers, item accept,
// newline and lead byte classification, job generation
// depends on nlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlc_front
   import nlc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_flush,
   input  wire logic       req_push,
   output logic            req_full,
   // configuration port
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [1:0] csr_wdata,
   // job queue side
   output logic            job_push,
   output job_type         job_data,
   input  wire logic       job_full
);

   logic [1:0] source_style_ff, source_style_in;
   logic [1:0] target_style_ff, target_style_in;
   logic [1:0] char_encoding_ff, char_encoding_in;
   logic       held_cr_ff, held_cr_in;
   logic       trail_expected_ff, trail_expected_in;

   logic       req_accept;
   logic       pre_cr;
   logic       do_plain;
   logic       emit_nl;
   logic [1:0] main_cnt;
   logic [7:0] main_byte0;
   logic [7:0] main_byte1;
   logic       has_job;

   // lead byte ranges of the two byte encodings
   function automatic logic is_lead(input logic [1:0] enc, input logic [7:0] b);
      logic lead;
      lead = 1'b0;
      unique case (enc)
         ENC_SJIS: lead = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
         ENC_EUC:  lead = (b == 8'h8E) || (b >= 8'hA1 && b <= 8'hFE);
         ENC_NONE, ENC_UTF8: lead = 1'b0;
      endcase
      return lead;
   endfunction

   assign req_full   = job_full;
   assign req_accept = req_push && !job_full;

   // configuration write decode
   always_comb begin
      source_style_in  = source_style_ff;
      target_style_in  = target_style_ff;
      char_encoding_in = char_encoding_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SOURCE_STYLE:  source_style_in  = csr_wdata;
            REG_TARGET_STYLE:  target_style_in  = csr_wdata;
            REG_CHAR_ENCODING: char_encoding_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // classify the item: optional leading cr, then up to two main bytes
   always_comb begin
      held_cr_in        = held_cr_ff;
      trail_expected_in = trail_expected_ff;
      pre_cr            = 1'b0;
      do_plain          = 1'b0;
      emit_nl           = 1'b0;
      main_cnt          = 2'd0;
      main_byte0        = 8'h00;
      main_byte1        = 8'h00;

      priority if (req_flush) begin
         held_cr_in        = 1'b0;
         trail_expected_in = 1'b0;
         if (held_cr_ff) begin
            main_cnt   = 2'd1;
            main_byte0 = CHAR_CR;
         end
      end else if (trail_expected_ff) begin
         trail_expected_in = 1'b0;
         main_cnt          = 2'd1;
         main_byte0        = req_byte_value;
      end else if (held_cr_ff) begin
         held_cr_in = 1'b0;
         if (req_byte_value == CHAR_LF) begin
            emit_nl = 1'b1;
         end else begin
            // lone cr goes out first, then the byte is handled normally
            pre_cr   = 1'b1;
            do_plain = 1'b1;
         end
      end else begin
         do_plain = 1'b1;
      end

      // ordinary byte handling
      if (do_plain) begin
         priority if (is_lead(char_encoding_ff, req_byte_value)) begin
            main_cnt          = 2'd1;
            main_byte0        = req_byte_value;
            trail_expected_in = 1'b1;
         end else if (req_byte_value == CHAR_CR) begin
            priority if (source_style_ff == STYLE_CR) begin
               emit_nl = 1'b1;
            end else if (source_style_ff == STYLE_CRLF) begin
               held_cr_in = 1'b1;
            end else begin
               main_cnt   = 2'd1;
               main_byte0 = req_byte_value;
            end
         end else if (req_byte_value == CHAR_LF && source_style_ff == STYLE_LF) begin
            emit_nl = 1'b1;
         end else begin
            main_cnt   = 2'd1;
            main_byte0 = req_byte_value;
         end
      end

      // newline in target style, none for the unused style code
      if (emit_nl) begin
         unique case (target_style_ff)
            STYLE_CR: begin
               main_cnt   = 2'd1;
               main_byte0 = CHAR_CR;
            end
            STYLE_LF: begin
               main_cnt   = 2'd1;
               main_byte0 = CHAR_LF;
            end
            STYLE_CRLF: begin
               main_cnt   = 2'd2;
               main_byte0 = CHAR_CR;
               main_byte1 = CHAR_LF;
            end
            default: main_cnt = 2'd0;
         endcase
      end
   end

   // merge into a job of at most two beats, extra bytes dropped
   always_comb begin
      if (pre_cr) begin
         job_data.first_byte  = CHAR_CR;
         job_data.second_byte = main_byte0;
         job_data.two_beats   = (main_cnt != 2'd0);
         has_job              = 1'b1;
      end else begin
         job_data.first_byte  = main_byte0;
         job_data.second_byte = main_byte1;
         job_data.two_beats   = (main_cnt == 2'd2);
         has_job              = (main_cnt != 2'd0);
      end
   end

   assign job_push = req_accept && has_job;

   // configuration and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         source_style_ff   <= SOURCE_STYLE_RESET;
         target_style_ff   <= TARGET_STYLE_RESET;
         char_encoding_ff  <= CHAR_ENCODING_RESET;
         held_cr_ff        <= 1'b0;
         trail_expected_ff <= 1'b0;
      end else begin
         source_style_ff  <= source_style_in;
         target_style_ff  <= target_style_in;
         char_encoding_ff <= char_encoding_in;
         if (req_accept) begin
            held_cr_ff        <= held_cr_in;
            trail_expected_ff <= trail_expected_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nlc_queue.sv =====
// job queue of the newline style converter: small fifo of classified items
// between front and back
// depends on nlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlc_queue
   import nlc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      head_data,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nlc_back.sv =====
// back of the newline style converter: splits jobs into beats and holds the
// result register
// depends on nlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlc_back
   import nlc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // job queue side
   input  wire job_type job_data,
   input  wire logic    job_empty,
   output logic         job_pop,
   // result channel
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_end_marker,
   output logic         rsp_empty,
   input  wire logic    rsp_pop
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_end_ff;
   logic       phase_ff, phase_in;
   logic       load;
   logic       take;
   logic       last_beat;
   logic [7:0] beat_byte;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_end_marker = out_end_ff;

   // result register is free or being emptied this cycle
   assign load      = !out_valid_ff || rsp_pop;
   assign take      = load && !job_empty;
   assign last_beat = !job_data.two_beats || phase_ff;
   assign beat_byte = phase_ff ? job_data.second_byte : job_data.first_byte;
   assign job_pop   = take && last_beat;

   // valid and beat phase
   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (take) begin
         out_valid_in = 1'b1;
         phase_in     = !last_beat;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= beat_byte;
         out_end_ff  <= last_beat;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/newline_style_converter.sv =====
// newline style converter top level: front, job queue and back
// depends on nlc_pkg, nlc_front, nlc_queue, nlc_back
//
// Rewrites the line endings of a byte stream (CR, LF or CRLF) into the
// configured target style; other bytes pass unchanged, and in Shift-JIS or
// EUC-JP mode the byte after a lead byte passes raw. Push one byte (or a
// flush) per cycle while full is low; results come out of a queue-like port,
// one byte per cycle while pop is held high. An item that gives two result
// bytes (a target CRLF, or a lone CR followed by another byte) passes them in
// turn through the single result register of the back end. Items that give
// no result (a held CR, a flush with nothing held) are used up at the front
// only and push no job. A job queue of QUEUE_DEPTH entries lets the front
// keep taking items while the result side stalls. end_marker is high on the
// last byte of each item. Configuration writes take effect at the next edge
// and must be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module newline_style_converter
   import nlc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_flush,
   input  wire logic       req_push,
   output logic            req_full,
   // result channel
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_end_marker,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   // configuration port
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [1:0] csr_wdata
);

   logic    q_push;
   job_type q_push_data;
   logic    q_full;
   logic    q_pop;
   job_type q_head_data;
   logic    q_empty;

   // classification front
   nlc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_byte_value (req_byte_value),
      .req_flush      (req_flush),
      .req_push       (req_push),
      .req_full       (req_full),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .job_push       (q_push),
      .job_data       (q_push_data),
      .job_full       (q_full)
   );

   // job queue
   nlc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head_data),
      .empty     (q_empty)
   );

   // beat emitting back
   nlc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_data       (q_head_data),
      .job_empty      (q_empty),
      .job_pop        (q_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

   // front never pushes into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job pushed into full queue");

   // back never pops an empty queue
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from empty queue");

   // reset leaves queue and result register empty
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (q_empty && rsp_empty))
      else $error("queue or result register not empty after reset");

endmodule

`default_nettype wire

// ===== sim/newline_style_converter_test.sv =====
// self-checking testbench for newline_style_converter: directed and random text
// streams through the push/pop channels, checked against a built-in line-ending predictor
// depends on nlc_pkg and the newline_style_converter rtl
`timescale 1ns / 1ps

module newline_style_converter_test;
   import nlc_pkg::*;

   // style code three: nothing recognized at the source, nothing emitted at the target
   localparam logic [1:0] STYLE_NONE = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 50;
   localparam int REPORT_LINES = 100;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       flush;
   } text_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
   } text_beat_type;

   logic       clock;
   logic       reset;
   logic [7:0] req_byte_value;
   logic       req_flush;
   logic       req_push;
   logic       req_full;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_marker;
   logic       rsp_empty;
   logic       rsp_pop;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [1:0] csr_wdata;

   newline_style_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_byte_value (req_byte_value),
      .req_flush      (req_flush),
      .req_push       (req_push),
      .req_full       (req_full),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   text_item_type pending_items[$];
   text_beat_type expected_beats[$];
   logic [7:0] item_bytes[$];

   // converter state as predicted
   logic [1:0] source_style_q;
   logic [1:0] target_style_q;
   logic [1:0] char_encoding_q;
   logic       held_cr_q;
   logic       trail_expected_q;

   int  send_idle_pct;
   int  recv_idle_pct;
   int  mismatch_count;
   int  stall_cycles;
   logic req_taken;
   text_beat_type want_beat;

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // newline bytes in the target style
   task automatic add_newline();
      case (target_style_q)
         STYLE_CR: item_bytes.push_back(CHAR_CR);
         STYLE_LF: item_bytes.push_back(CHAR_LF);
         STYLE_CRLF: begin
            item_bytes.push_back(CHAR_CR);
            item_bytes.push_back(CHAR_LF);
         end
         default: ;
      endcase
   endtask

   // a byte outside any pending trail or held cr
   task automatic convert_plain(input logic [7:0] value);
      logic lead;
      lead = (char_encoding_q == ENC_SJIS &&
              ((value >= 8'h81 && value <= 8'h9F) || (value >= 8'hE0 && value <= 8'hFC))) ||
             (char_encoding_q == ENC_EUC &&
              (value == 8'h8E || (value >= 8'hA1 && value <= 8'hFE)));
      if (lead) begin
         item_bytes.push_back(value);
         trail_expected_q = 1'b1;
      end else if (value == CHAR_CR) begin
         if (source_style_q == STYLE_CR)
            add_newline();
         else if (source_style_q == STYLE_CRLF)
            held_cr_q = 1'b1;
         else
            item_bytes.push_back(value);
      end else if (value == CHAR_LF && source_style_q == STYLE_LF) begin
         add_newline();
      end else begin
         item_bytes.push_back(value);
      end
   endtask

   // expected output beats of one accepted item, at most two
   task automatic predict_conversion(input logic [7:0] value, input logic flush);
      int beats;
      item_bytes.delete();
      if (flush) begin
         if (held_cr_q)
            item_bytes.push_back(CHAR_CR);
         held_cr_q = 1'b0;
         trail_expected_q = 1'b0;
      end else if (trail_expected_q) begin
         item_bytes.push_back(value);
         trail_expected_q = 1'b0;
      end else if (held_cr_q) begin
         held_cr_q = 1'b0;
         if (value == CHAR_LF) begin
            add_newline();
         end else begin
            item_bytes.push_back(CHAR_CR);
            convert_plain(value);
         end
      end else begin
         convert_plain(value);
      end
      beats = (item_bytes.size() > 2) ? 2 : item_bytes.size();
      for (int k = 0; k < beats; k++)
         expected_beats.push_back('{out_byte: item_bytes[k], end_marker: (k == beats - 1)});
   endtask

   // sampling: acceptance, prediction, result checks and stall watchdog
   always @(posedge clock) begin
      req_taken = !reset && req_push && !req_full;
      if (reset) begin
         source_style_q = SOURCE_STYLE_RESET;
         target_style_q = TARGET_STYLE_RESET;
         char_encoding_q = CHAR_ENCODING_RESET;
         held_cr_q = 1'b0;
         trail_expected_q = 1'b0;
      end else begin
         if (req_taken)
            predict_conversion(req_byte_value, req_flush);
         if (csr_we) begin
            case (csr_index)
               REG_SOURCE_STYLE:  source_style_q = csr_wdata;
               REG_TARGET_STYLE:  target_style_q = csr_wdata;
               REG_CHAR_ENCODING: char_encoding_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_out_byte, 8'h00);
            end else begin
               want_beat = expected_beats.pop_front();
               if (rsp_out_byte !== want_beat.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want_beat.out_byte);
               if (rsp_end_marker !== want_beat.end_marker)
                  report_mismatch("end_marker", 8'(rsp_end_marker), 8'(want_beat.end_marker));
            end
         end
      end
      if (reset || req_taken || csr_we || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // input driver: next pending item, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_byte_value <= pending_items[0].byte_value;
            req_flush <= pending_items[0].flush;
            req_push <= 1'b1;
            void'(pending_items.pop_front());
         end else begin
            req_push <= 1'b0;
            req_byte_value <= 8'($urandom_range(255));
            req_flush <= 1'($urandom_range(1));
         end
      end
   end

   // result side: random stalls
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic push_byte(input logic [7:0] value);
      pending_items.push_back('{byte_value: value, flush: 1'b0});
   endtask

   task automatic push_flush();
      pending_items.push_back('{byte_value: 8'($urandom_range(255)), flush: 1'b1});
   endtask

   // sender holds off until every expected beat is out and the block has settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_push || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input logic [1:0] source, input logic [1:0] target,
                               input logic [1:0] encoding);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_SOURCE_STYLE;
      csr_wdata <= source;
      @(negedge clock);
      csr_index <= REG_TARGET_STYLE;
      csr_wdata <= target;
      @(negedge clock);
      csr_index <= REG_CHAR_ENCODING;
      csr_wdata <= encoding;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // text-like random stream: newlines, lead/trail pairs, flushes and noise
   task automatic add_random_text(input int count);
      int made;
      int pick;
      logic [7:0] lead;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            push_byte(CHAR_CR);
            made += 1;
         end else if (pick < 22) begin
            push_byte(CHAR_LF);
            made += 1;
         end else if (pick < 34) begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
            made += 2;
         end else if (pick < 48) begin
            if ($urandom_range(1))
               lead = $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
                                        : 8'($urandom_range(8'hFC, 8'hE0));
            else
               lead = $urandom_range(3) == 0 ? 8'h8E : 8'($urandom_range(8'hFE, 8'hA1));
            push_byte(lead);
            if ($urandom_range(2) == 0)
               push_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
            else
               push_byte(8'($urandom_range(255)));
            made += 2;
         end else if (pick < 52) begin
            push_flush();
            made += 1;
         end else begin
            push_byte(8'($urandom_range(255)));
            made += 1;
         end
      end
   endtask

   // stimulus sequence and verdict
   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_byte_value = 8'h00;
      req_flush = 1'b0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_SOURCE_STYLE;
      csr_wdata = 2'd0;
      req_taken = 1'b0;
      mismatch_count = 0;
      stall_cycles = 0;
      send_idle_pct = 36;
      recv_idle_pct = 45;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: crlf in, lf out, no encoding
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      // lone cr followed by a letter
      push_byte(CHAR_CR);
      push_byte(8'h41);
      // lone lf passes raw
      push_byte(CHAR_LF);
      // flush releases a held cr, then a flush with nothing held
      push_byte(CHAR_CR);
      push_flush();
      push_flush();
      push_byte(8'h00);
      push_byte(8'hFF);
      // cr left held across the style change
      push_byte(CHAR_CR);
      wait_drained();

      write_config(STYLE_CR, STYLE_CRLF, ENC_SJIS);
      // held cr then a cr that is itself a newline: output capped at two beats
      push_byte(CHAR_CR);
      push_byte(CHAR_CR);
      // trail byte passes raw even when it is a cr
      push_byte(8'h81);
      push_byte(CHAR_CR);
      push_byte(8'hFC);
      push_byte(CHAR_LF);
      // flush after a lead byte drops the trail
      push_byte(8'hE0);
      push_flush();
      push_byte(CHAR_LF);
      wait_drained();

      // newline that produces nothing, euc lead bytes
      write_config(STYLE_LF, STYLE_NONE, ENC_EUC);
      push_byte(CHAR_LF);
      push_byte(8'h8E);
      push_byte(CHAR_LF);
      push_byte(8'hFE);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: write_config(STYLE_CR, STYLE_CR, ENC_NONE);
            1: write_config(STYLE_NONE, STYLE_NONE, ENC_EUC);
            2: write_config(STYLE_CRLF, STYLE_CRLF, ENC_UTF8);
            default: write_config(2'($urandom_range(3)), 2'($urandom_range(3)),
                                  2'($urandom_range(3)));
         endcase
         if (phase < 4) begin
            send_idle_pct = 36;
            recv_idle_pct = 45;
         end else if (phase < 7) begin
            send_idle_pct = 45;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         add_random_text(PHASE_ITEMS);
      end
      wait_drained();

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
